[rtl/core/sofcrc_pkg.sv]
`timescale 1ns / 1ps

package sofcrc_pkg;

    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_VERSION  = 2'd2;

    // Result kinds and end-of-frame status codes.
    localparam logic       KIND_PAYLOAD  = 1'b0;
    localparam logic       KIND_END      = 1'b1;
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BAD_VER = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] exp_version;
    } cfg_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [15:0] seq_number;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [1:0]  frame_status;
    } res_t;

    // One byte of CRC-16/CCITT, MSB first, unrolled over eight bits.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/sofcrc_parser.sv]
`timescale 1ns / 1ps

module sofcrc_parser
    import sofcrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRCLO   = 3'd4;
    localparam logic [2:0] PH_CRCHI   = 3'd5;

    localparam logic [2:0] HDR_VERSION = 3'd0;
    localparam logic [2:0] HDR_TYPE    = 3'd1;
    localparam logic [2:0] HDR_FLAGS   = 3'd2;
    localparam logic [2:0] HDR_SEQ_LO  = 3'd3;
    localparam logic [2:0] HDR_SEQ_HI  = 3'd4;
    localparam logic [2:0] HDR_LEN_LO  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [7:0]  frame_flags_reg, frame_flags_next;
    logic [15:0] frame_seq_reg, frame_seq_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  crc_low_byte_reg, crc_low_byte_next;
    logic        version_good_reg, version_good_next;

    logic [15:0] crc_upd;
    logic [15:0] length_full;
    logic [15:0] count_inc;
    logic [15:0] crc_got;

    assign crc_upd     = crc16_byte(running_crc_reg, rx_byte);
    assign length_full = {rx_byte, frame_length_reg[7:0]};
    assign count_inc   = payload_count_reg + 16'd1;
    assign crc_got     = {rx_byte, crc_low_byte_reg};

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        frame_type_next    = frame_type_reg;
        frame_flags_next   = frame_flags_reg;
        frame_seq_next     = frame_seq_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        running_crc_next   = running_crc_reg;
        crc_low_byte_next  = crc_low_byte_reg;
        version_good_next  = version_good_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.msg_type       = frame_type_reg;
        res.msg_flags      = frame_flags_reg;
        res.seq_number     = frame_seq_reg;
        res.payload_length = frame_length_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == cfg.start_first)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    // The second start byte is tested first, so a repeated
                    // first start byte keeps the hunt waiting here.
                    if (rx_byte == cfg.start_second)
                    begin
                        phase_next        = PH_HEADER;
                        header_count_next = HDR_VERSION;
                        running_crc_next  = CRC_INIT;
                    end
                    else if (rx_byte != cfg.start_first)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_HEADER:
                begin
                    running_crc_next  = crc_upd;
                    header_count_next = header_count_reg + 3'd1;
                    unique case (header_count_reg)
                        HDR_VERSION: version_good_next = (rx_byte == cfg.exp_version);
                        HDR_TYPE:    frame_type_next   = rx_byte;
                        HDR_FLAGS:   frame_flags_next  = rx_byte;
                        HDR_SEQ_LO:  frame_seq_next    = {8'h00, rx_byte};
                        HDR_SEQ_HI:  frame_seq_next    = {rx_byte, frame_seq_reg[7:0]};
                        HDR_LEN_LO:  frame_length_next = {8'h00, rx_byte};
                        default:
                        begin
                            // Length high byte, the last byte of the header.
                            frame_length_next  = length_full;
                            header_count_next  = HDR_VERSION;
                            payload_count_next = '0;
                            phase_next = (length_full == 16'd0) ? PH_CRCLO : PH_PAYLOAD;
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    running_crc_next   = crc_upd;
                    payload_count_next = count_inc;
                    res_valid          = 1'b1;
                    res.item_kind      = KIND_PAYLOAD;
                    res.payload_byte   = rx_byte;
                    res.byte_index     = payload_count_reg;
                    if (count_inc == frame_length_reg)
                    begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO:
                begin
                    crc_low_byte_next = rx_byte;
                    phase_next        = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    res_valid     = 1'b1;
                    res.item_kind = KIND_END;
                    phase_next    = PH_HUNT1;
                    if (!version_good_reg)
                    begin
                        res.frame_status = STATUS_BAD_VER;
                    end
                    else if (crc_got != running_crc_reg)
                    begin
                        res.frame_status = STATUS_BAD_CRC;
                    end
                    else
                    begin
                        res.frame_status = STATUS_OK;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT1;
            header_count_reg  <= '0;
            frame_type_reg    <= '0;
            frame_flags_reg   <= '0;
            frame_seq_reg     <= '0;
            frame_length_reg  <= '0;
            payload_count_reg <= '0;
            running_crc_reg   <= CRC_INIT;
            crc_low_byte_reg  <= '0;
            version_good_reg  <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_type_reg    <= frame_type_next;
            frame_flags_reg   <= frame_flags_next;
            frame_seq_reg     <= frame_seq_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            running_crc_reg   <= running_crc_next;
            crc_low_byte_reg  <= crc_low_byte_next;
            version_good_reg  <= version_good_next;
        end
    end

`ifndef SYNTHESIS
    a_hdr_count_only_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (header_count_reg != 3'd0) |-> (phase_reg == PH_HEADER))
        else $error("header count left nonzero outside the header");

    a_payload_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_count_reg < frame_length_reg))
        else $error("payload count ran past the declared length");

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_CRCHI) |=> (phase_reg == PH_HUNT1))
        else $error("end of frame did not return to hunting");
`endif

endmodule

[rtl/core/sofcrc_out_buf.sv]
`timescale 1ns / 1ps

module sofcrc_out_buf
    import sofcrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    input  logic out_stall,
    output logic out_valid,
    output res_t out_data,
    output logic full
);

    // Two entries: one presents the result, the other absorbs a result
    // produced while the consumer stalls.
    res_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |-> !push)
        else $error("result pushed into a full output buffer");
`endif

endmodule

[rtl/core/sof_crc16_packet_deframer.sv]
// A result transaction is written into the output buffer when its input byte is taken and is offered from there.
// Throughput: one byte per cycle; the input stalls only while both output buffer entries hold
// results that the consumer has not yet taken.
// Reset (rst_n, asynchronous, active low) clears the configuration registers to zero, sends the
// parser back to hunting for the first start byte and empties the output buffer.
`timescale 1ns / 1ps

module sof_crc16_packet_deframer
    import sofcrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,

    // Received byte channel.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,

    // Result channel.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 item_kind,
    output logic [7:0]           msg_type,
    output logic [7:0]           msg_flags,
    output logic [15:0]          seq_number,
    output logic [15:0]          payload_length,
    output logic [7:0]           payload_byte,
    output logic [15:0]          byte_index,
    output logic [1:0]           frame_status
);

    // The configuration registers are always writable. A write lands at the
    // clock edge and is seen by the very next byte, also in mid-frame. An
    // index with no register behind it is dropped.
    cfg_t cfg_reg, cfg_next;

    logic in_accept;
    logic res_valid;
    res_t res;
    res_t out_data;
    logic buf_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_FIRST:  cfg_next.start_first  = cfg_data;
                REG_START_SECOND: cfg_next.start_second = cfg_data;
                REG_EXP_VERSION:  cfg_next.exp_version  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // A byte is taken whenever the output buffer has a free entry. The
    // parser walks hunt, header, payload and CRC phases; every payload byte
    // becomes a payload transaction as it arrives, and the high CRC byte
    // becomes the end-of-frame transaction with its status. A frame with a
    // bad version or CRC is still consumed to its declared length.
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !in_stall;

    sofcrc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // The output buffer decouples the two sides, so a stalled consumer does
    // not stop the next byte from being taken.
    sofcrc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign item_kind      = out_data.item_kind;
    assign msg_type       = out_data.msg_type;
    assign msg_flags      = out_data.msg_flags;
    assign seq_number     = out_data.seq_number;
    assign payload_length = out_data.payload_length;
    assign payload_byte   = out_data.payload_byte;
    assign byte_index     = out_data.byte_index;
    assign frame_status   = out_data.frame_status;

endmodule
